// ===== rtl/core/bsc_pkg.sv =====
// Shared types and constants for the Banker's safety check block.
// Depends on nothing; used by the top level and the port checker.
package bsc_pkg;

  // Input opcodes
  localparam logic [1:0] OP_LOAD_ALLOC = 2'd0;
  localparam logic [1:0] OP_LOAD_CLAIM = 2'd1;
  localparam logic [1:0] OP_LOAD_AVAIL = 2'd2;
  localparam logic [1:0] OP_START      = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS  = 4;
  localparam int unsigned CFG_DATA_BITS = 5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PROCS_IN_USE = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RES_IN_USE   = 4'd1;

  localparam int unsigned PID_BITS = 4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  proc_index;
    logic [2:0]  res_index;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic                is_verdict;
    logic [PID_BITS-1:0] process_id;
    logic                safe;
    logic                last;
  } out_item_t;

endpackage

// ===== rtl/core/bsc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bankers_safety_check.sv =====
// Banker's algorithm safety check: table RAM, work vector and check sequencer.
// Depends on bsc_pkg (types, opcodes) and bsc_ram (table and order memories).
//
// Usage and timing. Items enter through start/busy: an item is taken at a clock
// edge with start high and busy low. Load-available items finish in that cycle.
// Load-allocation and load-claim items share one table row word per entry
// (claim in the upper half, allocation in the lower), so they do a
// read-modify-write and keep busy high through the S_LD_WR write state. A start
// item runs the check on a sequencer that walks the table RAM one resource per
// cycle: it seeds work from available, then takes every process in every pass
// through S_PICK and S_NEXT; an unfinished process with res_in_use nonzero gets
// a need test and, when it fits, its allocation is added to work. At most
// procs_in_use passes run. Results then leave one per cycle on out_valid: the
// safe sequence (one entry per process in use, read back from the order RAM
// after the S_EMIT_RD setup state) followed by the verdict, or the verdict
// alone. out_valid is a strobe: the receiver must take every result in
// the cycle it appears. busy drops in the cycle the verdict is on the outputs.
// Configuration writes are always taken (cfg_ready is tied high) and must only
// happen while busy is low and no results are pending. Tables and the available
// vector have no reset: a check must not read an entry that was never loaded.
module bankers_safety_check #(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_RES    = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  bsc_pkg::in_item_t                  in_data,
  // result channel
  output logic                               out_valid,
  output bsc_pkg::out_item_t                 out_data,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bsc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // Index and count widths
  localparam int PIW       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RIW       = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int CW        = $clog2(MAX_PROCS + 1);
  localparam int RCW       = $clog2(MAX_RES + 1);
  // Work never overflows: available plus every allocation.
  localparam int WORK_BITS = VALUE_BITS + CW;
  localparam int TAW       = PIW + RIW;
  localparam int TBL_DEPTH = 2 ** TAW;
  localparam int ORD_DEPTH = 2 ** PIW;
  localparam int PID_W_LOCAL = bsc_pkg::PID_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_WR,    // merge load into table word
    S_INIT,     // seed work from available
    S_PICK,     // look at process i
    S_TEST_RD,  // first need read in flight
    S_TEST,     // compare need against work, one resource per cycle
    S_ADD_RD,   // first allocation read in flight
    S_ADD,      // add allocation to work, one resource per cycle
    S_NEXT,     // step to next process / next pass
    S_EMIT_RD,  // first order read in flight
    S_EMIT,     // stream safe sequence
    S_VERDICT
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [4:0] procs_r;
  logic [3:0] res_r;
  logic [CW-1:0]  n_eff;
  logic [RCW-1:0] m_eff;

  // Check bookkeeping
  logic [MAX_PROCS-1:0] finished_r;
  logic [CW-1:0]        count_r;
  logic                 found_r;
  logic                 safe_r;
  logic [PIW-1:0]       i_r;
  logic [RIW-1:0]       j_r;
  logic [PIW-1:0]       k_r;

  // Datapath storage
  logic [VALUE_BITS-1:0] avail_r [MAX_RES];
  logic [WORK_BITS-1:0]  work_r  [MAX_RES];

  // Pending table load
  logic                  ld_claim_r;
  logic [TAW-1:0]        ld_addr_r;
  logic [VALUE_BITS-1:0] ld_val_r;

  // Memory ports
  logic                    tbl_we;
  logic [TAW-1:0]          tbl_raddr;
  logic [2*VALUE_BITS-1:0] tbl_wdata, tbl_rdata;
  logic                    ord_we;
  logic [PIW-1:0]          ord_raddr;
  logic [PID_W_LOCAL-1:0]  ord_rdata;

  // Decode helpers
  logic                  accept;
  logic                  proc_ok, res_ok;
  logic                  tbl_load;
  logic [VALUE_BITS-1:0] claim_v, alloc_v, need_v;
  logic                  test_fail;
  logic                  i_last, j_last, k_last;
  logic                  fin_now;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;

  assign n_eff = (int'(procs_r) > MAX_PROCS) ? CW'(MAX_PROCS) : CW'(procs_r);
  assign m_eff = (int'(res_r) > MAX_RES) ? RCW'(MAX_RES) : RCW'(res_r);

  assign proc_ok  = int'(in_data.proc_index) < MAX_PROCS;
  assign res_ok   = int'(in_data.res_index) < MAX_RES;
  assign tbl_load = accept && proc_ok && res_ok &&
                    ((in_data.opcode == bsc_pkg::OP_LOAD_ALLOC) ||
                     (in_data.opcode == bsc_pkg::OP_LOAD_CLAIM));

  // Table word: claim high, allocation low
  assign claim_v   = tbl_rdata[2*VALUE_BITS-1:VALUE_BITS];
  assign alloc_v   = tbl_rdata[VALUE_BITS-1:0];
  assign need_v    = claim_v - alloc_v;
  // negative need always fits
  assign test_fail = (claim_v > alloc_v) && (WORK_BITS'(need_v) > work_r[j_r]);

  assign i_last = (CW'(i_r) + CW'(1)) == n_eff;
  assign j_last = (RCW'(j_r) + RCW'(1)) == m_eff;
  assign k_last = (CW'(k_r) + CW'(1)) == n_eff;

  // Process i completes in this cycle
  assign fin_now = ((state_r == S_PICK) && !finished_r[i_r] && (m_eff == '0)) ||
                   ((state_r == S_ADD) && j_last);

  // Table RAM addressing: next read is presented while the current one is used
  always_comb begin
    unique case (state_r)
      S_IDLE:  tbl_raddr = {PIW'(in_data.proc_index), RIW'(in_data.res_index)};
      S_TEST,
      S_ADD:   tbl_raddr = {i_r, RIW'(j_r + 1'b1)};
      default: tbl_raddr = {i_r, j_r};
    endcase
  end

  assign tbl_we    = (state_r == S_LD_WR);
  assign tbl_wdata = ld_claim_r ? {ld_val_r, alloc_v} : {claim_v, ld_val_r};

  assign ord_we    = fin_now;
  assign ord_raddr = (state_r == S_EMIT) ? PIW'(k_r + 1'b1) : k_r;

  bsc_ram #(
    .WIDTH (2 * VALUE_BITS),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ld_addr_r),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  bsc_ram #(
    .WIDTH (PID_W_LOCAL),
    .DEPTH (ORD_DEPTH)
  ) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (PIW'(count_r)),
    .wdata (PID_W_LOCAL'(i_r)),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_data.opcode == bsc_pkg::OP_START)) begin
          state_nxt = S_INIT;
        end else if (tbl_load) begin
          state_nxt = S_LD_WR;
        end
      end
      S_LD_WR:   state_nxt = S_IDLE;
      S_INIT:    state_nxt = (n_eff == '0) ? S_VERDICT : S_PICK;
      S_PICK: begin
        if (finished_r[i_r] || (m_eff == '0)) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_TEST_RD;
        end
      end
      S_TEST_RD: state_nxt = S_TEST;
      S_TEST: begin
        if (test_fail) begin
          state_nxt = S_NEXT;
        end else if (j_last) begin
          state_nxt = S_ADD_RD;
        end
      end
      S_ADD_RD:  state_nxt = S_ADD;
      S_ADD: begin
        if (j_last) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        priority if (!i_last) begin
          state_nxt = S_PICK;
        end else if (count_r == n_eff) begin
          state_nxt = S_EMIT_RD;
        end else if (found_r) begin
          state_nxt = S_PICK;
        end else begin
          state_nxt = S_VERDICT;
        end
      end
      S_EMIT_RD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (k_last) begin
          state_nxt = S_VERDICT;
        end
      end
      S_VERDICT: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // State and registered result outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_EMIT) || (state_r == S_VERDICT);
    end
    if (state_r == S_EMIT) begin
      out_data.is_verdict <= 1'b0;
      out_data.process_id <= ord_rdata;
      out_data.safe       <= 1'b0;
      out_data.last       <= 1'b0;
    end else begin
      out_data.is_verdict <= 1'b1;
      out_data.process_id <= '0;
      out_data.safe       <= safe_r;
      out_data.last       <= 1'b1;
    end
  end

  // Configuration and check control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      procs_r    <= 5'd16;
      res_r      <= 4'd8;
      finished_r <= '0;
      count_r    <= '0;
      found_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bsc_pkg::CFG_PROCS_IN_USE) begin
          procs_r <= cfg_data[4:0];
        end else if (cfg_index == bsc_pkg::CFG_RES_IN_USE) begin
          res_r <= cfg_data[3:0];
        end
      end
      if (state_r == S_INIT) begin
        finished_r <= '0;
        count_r    <= '0;
        found_r    <= 1'b0;
      end else if (fin_now) begin
        finished_r[i_r] <= 1'b1;
        count_r         <= count_r + 1'b1;
        found_r         <= 1'b1;
      end else if ((state_r == S_NEXT) && i_last) begin
        found_r <= 1'b0;   // fresh pass
      end
    end
  end

  // Datapath: indexes, work vector, available vector, load staging
  always_ff @(posedge clk) begin
    if (accept) begin
      ld_claim_r <= (in_data.opcode == bsc_pkg::OP_LOAD_CLAIM);
      ld_addr_r  <= {PIW'(in_data.proc_index), RIW'(in_data.res_index)};
      ld_val_r   <= VALUE_BITS'(in_data.amount);
      if ((in_data.opcode == bsc_pkg::OP_LOAD_AVAIL) && res_ok) begin
        avail_r[RIW'(in_data.res_index)] <= VALUE_BITS'(in_data.amount);
      end
    end

    unique case (state_r)
      S_INIT: begin
        for (int r = 0; r < MAX_RES; r++) begin
          work_r[r] <= WORK_BITS'(avail_r[r]);
        end
        i_r    <= '0;
        safe_r <= 1'b1;   // zero processes: trivially safe
      end
      S_PICK: j_r <= '0;
      S_TEST: begin
        if (j_last) begin
          j_r <= '0;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      S_ADD: begin
        work_r[j_r] <= work_r[j_r] + WORK_BITS'(alloc_v);
        j_r         <= j_r + 1'b1;
      end
      S_NEXT: begin
        if (i_last) begin
          i_r    <= '0;
          safe_r <= (count_r == n_eff);
        end else begin
          i_r <= i_r + 1'b1;
        end
        k_r <= '0;
      end
      S_EMIT: k_r <= k_r + 1'b1;
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/bsc_checker.sv =====
// Port-level checker for bankers_safety_check, bound to the top level.
// Depends on bsc_pkg for the transaction types and opcodes.
module bsc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input bsc_pkg::in_item_t   in_data,
  input logic                out_valid,
  input bsc_pkg::out_item_t  out_data
);

  // Sequence entries stream back to back until the verdict
  a_seq_streams: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_verdict |=> out_valid)
    else $error("safe sequence broken before verdict");

  a_last_on_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == out_data.is_verdict))
    else $error("last does not mark the verdict");

  a_entry_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_verdict |-> !out_data.safe)
    else $error("sequence entry carries safe flag");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.opcode == bsc_pkg::OP_START) |=> busy)
    else $error("check transaction did not raise busy");

  a_result_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a running check");

endmodule

bind bankers_safety_check bsc_checker u_bsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== sim/tb_bankers_safety_check.sv =====
// Self-checking testbench for bankers_safety_check: drives loads, checks and
// register writes, predicts every result in a scoreboard class and compares.
// Depends on bsc_pkg and the bankers_safety_check RTL only.
`timescale 1ns / 100ps

module tb_bankers_safety_check;

  // Register indexes the block does not decode; writes to them must be dropped.
  localparam logic [bsc_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 4'h2;
  localparam logic [bsc_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 4'hF;

  // Longest legal silence is one full check at 16 x 8; keep margin.
  localparam int unsigned QUIET_LIMIT = 30000;

  // ---------------------------------------------------------------------------
  // Scoreboard: own copy of the tables and registers, runs the safety walk
  // for each start transaction and queues the results it must produce.
  // ---------------------------------------------------------------------------
  class safety_check_ledger;
    bit [15:0]          alloc_tbl [16][8];
    bit [15:0]          claim_tbl [16][8];
    bit [15:0]          avail_vec [8];
    int unsigned        proc_limit;
    int unsigned        res_limit;
    bsc_pkg::out_item_t awaited_results [$];
    int unsigned        mismatches;

    function new();
      proc_limit = 16;
      res_limit  = 8;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    // Oversized values clamp to the table size; res_in_use only keeps 4 bits.
    function void record_write(logic [bsc_pkg::CFG_IDX_BITS-1:0] idx,
                               logic [bsc_pkg::CFG_DATA_BITS-1:0] val);
      case (idx)
        bsc_pkg::CFG_PROCS_IN_USE: proc_limit = (val > 16) ? 16 : val;
        bsc_pkg::CFG_RES_IN_USE:   res_limit  = (val[3:0] > 8) ? 8 : val[3:0];
        default: ;
      endcase
    endfunction

    function void record_command(bsc_pkg::in_item_t item);
      int                 work [8];
      bit                 retired [16];
      bit [3:0]           order [16];
      int                 n_done;
      bit                 progress;
      bit                 fits;
      bsc_pkg::out_item_t entry;
      case (item.opcode)
        bsc_pkg::OP_LOAD_ALLOC: alloc_tbl[item.proc_index][item.res_index] = item.amount;
        bsc_pkg::OP_LOAD_CLAIM: claim_tbl[item.proc_index][item.res_index] = item.amount;
        bsc_pkg::OP_LOAD_AVAIL: avail_vec[item.res_index] = item.amount;
        default: begin
          for (int c = 0; c < 8; c++) work[c] = (c < res_limit) ? int'(avail_vec[c]) : 0;
          for (int r = 0; r < 16; r++) begin
            retired[r] = 1'b0;
            order[r]   = 4'd0;
          end
          n_done = 0;
          while (n_done < proc_limit) begin
            progress = 1'b0;
            for (int r = 0; r < proc_limit; r++) begin
              if (!retired[r]) begin
                fits = 1'b1;
                for (int c = 0; c < res_limit; c++)
                  if (int'(claim_tbl[r][c]) - int'(alloc_tbl[r][c]) > work[c]) fits = 1'b0;
                if (fits) begin
                  // allocation returns to the pool at once, later rows see it
                  for (int c = 0; c < res_limit; c++) work[c] += int'(alloc_tbl[r][c]);
                  order[n_done] = r[3:0];
                  n_done++;
                  retired[r] = 1'b1;
                  progress   = 1'b1;
                end
              end
            end
            if (!progress) break;
          end
          entry.process_id = 4'd0;
          entry.safe       = 1'b0;
          entry.last       = 1'b0;
          entry.is_verdict = 1'b0;
          if (n_done == proc_limit) begin
            for (int r = 0; r < proc_limit; r++) begin
              entry.process_id = order[r];
              awaited_results.push_back(entry);
            end
            entry.process_id = 4'd0;
            entry.safe       = 1'b1;
          end
          entry.is_verdict = 1'b1;
          entry.last       = 1'b1;
          awaited_results.push_back(entry);
        end
      endcase
    endfunction

    function void compare_result(bsc_pkg::out_item_t got);
      bsc_pkg::out_item_t want;
      if (awaited_results.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result verdict=%0b pid=%0d safe=%0b last=%0b",
                   $realtime, got.is_verdict, got.process_id, got.safe, got.last);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.is_verdict !== want.is_verdict || got.process_id !== want.process_id ||
          got.safe !== want.safe || got.last !== want.last) begin
        if (mismatches < 10)
          $display({"[%0t] mismatch: exp verdict=%0b pid=%0d safe=%0b last=%0b,",
                    " got verdict=%0b pid=%0d safe=%0b last=%0b"},
                   $realtime, want.is_verdict, want.process_id, want.safe, want.last,
                   got.is_verdict, got.process_id, got.safe, got.last);
        mismatches++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT and its signals
  // ---------------------------------------------------------------------------
  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  bsc_pkg::in_item_t                 in_data;
  logic                              out_valid;
  bsc_pkg::out_item_t                out_data;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [bsc_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [bsc_pkg::CFG_DATA_BITS-1:0] cfg_data;

  bankers_safety_check u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  safety_check_ledger ledger;

  // Which entries have been loaded since reset. A check may only run once every
  // entry inside the current procs x res window (and avail) has been written.
  bit alloc_set [16][8];
  bit claim_set [16][8];
  bit avail_set [8];

  int unsigned sender_idle_pct = 19;
  int unsigned quiet_cycles = 0;

  // Register settings for the random part, three per phase. Extremes included:
  // 31 procs clamps to 16, res 15 clamps to 8, res 17 keeps only 4 bits (1).
  int unsigned plan_procs [9] = '{3, 31, 1, 4, 2, 9, 16, 6, 1};
  int unsigned plan_res   [9] = '{2, 1, 15, 4, 8, 3, 17, 5, 8};

  // Results are strobes: sample pre-edge values at every rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) ledger.compare_result(out_data);
  end

  // Watchdog: counts edges at which no transaction of any kind completed.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one command transaction; start stays high into the next call unless
  // the sender idles, so start never gets two updates in one time step.
  task automatic send_item(input bsc_pkg::in_item_t item);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    ledger.record_command(item);
    case (item.opcode)
      bsc_pkg::OP_LOAD_ALLOC: alloc_set[item.proc_index][item.res_index] = 1'b1;
      bsc_pkg::OP_LOAD_CLAIM: claim_set[item.proc_index][item.res_index] = 1'b1;
      bsc_pkg::OP_LOAD_AVAIL: avail_set[item.res_index] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic load_entry(input logic [1:0] op, input int unsigned row,
                            input int unsigned col, input int unsigned amt);
    bsc_pkg::in_item_t item;
    item.opcode     = op;
    item.proc_index = row[3:0];
    item.res_index  = col[2:0];
    item.amount     = amt[15:0];
    send_item(item);
  endtask

  // Start transaction; the other fields are don't-care and get noise.
  task automatic launch_check();
    bsc_pkg::in_item_t item;
    logic [31:0]       noise;
    noise           = $urandom;
    item            = noise[$bits(bsc_pkg::in_item_t)-1:0];
    item.opcode     = bsc_pkg::OP_START;
    send_item(item);
  endtask

  // Mostly small counts so needs and work stay comparable; sometimes full range.
  function automatic int unsigned pick_amount();
    return ($urandom_range(0, 99) < 8) ? $urandom_range(0, 65535) : $urandom_range(0, 60);
  endfunction

  // Usually inside the active window, one time in four anywhere in the table.
  function automatic int unsigned pick_index(int unsigned limit, int unsigned span);
    if (limit == 0 || $urandom_range(0, 3) == 0) return $urandom_range(0, span - 1);
    return $urandom_range(0, limit - 1);
  endfunction

  task automatic random_load();
    int unsigned sel;
    sel = $urandom_range(0, 2);
    case (sel)
      0: load_entry(bsc_pkg::OP_LOAD_ALLOC, pick_index(ledger.proc_limit, 16),
                    pick_index(ledger.res_limit, 8), pick_amount());
      1: load_entry(bsc_pkg::OP_LOAD_CLAIM, pick_index(ledger.proc_limit, 16),
                    pick_index(ledger.res_limit, 8), pick_amount());
      default: load_entry(bsc_pkg::OP_LOAD_AVAIL, $urandom_range(0, 15),
                          pick_index(ledger.res_limit, 8), pick_amount());
    endcase
  endtask

  // Load whatever the next check would read but was never written.
  task automatic fill_tables();
    for (int r = 0; r < ledger.proc_limit; r++)
      for (int c = 0; c < ledger.res_limit; c++) begin
        if (!alloc_set[r][c]) load_entry(bsc_pkg::OP_LOAD_ALLOC, r, c, pick_amount());
        if (!claim_set[r][c]) load_entry(bsc_pkg::OP_LOAD_CLAIM, r, c, pick_amount());
      end
    for (int c = 0; c < ledger.res_limit; c++)
      if (!avail_set[c])
        load_entry(bsc_pkg::OP_LOAD_AVAIL, $urandom_range(0, 15), c, pick_amount());
  endtask

  // Drain: wait until all results are in and the block is not busy, which also
  // covers a trailing load read-modify-write, before registers may change.
  task automatic settle_block();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bsc_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [bsc_pkg::CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.record_write(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    ledger    = new();
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two processes, two resources, extreme amounts.
    // P1 has a negative need on res 0 and goes first, freeing 65535 so P0 fits.
    write_reg(bsc_pkg::CFG_PROCS_IN_USE, 5'd2);
    write_reg(bsc_pkg::CFG_RES_IN_USE, 5'd2);
    load_entry(bsc_pkg::OP_LOAD_ALLOC, 0, 0, 0);
    load_entry(bsc_pkg::OP_LOAD_ALLOC, 0, 1, 1);
    load_entry(bsc_pkg::OP_LOAD_CLAIM, 0, 0, 65535);
    load_entry(bsc_pkg::OP_LOAD_CLAIM, 0, 1, 1);
    load_entry(bsc_pkg::OP_LOAD_ALLOC, 1, 0, 65535);
    load_entry(bsc_pkg::OP_LOAD_ALLOC, 1, 1, 0);
    load_entry(bsc_pkg::OP_LOAD_CLAIM, 1, 0, 0);
    load_entry(bsc_pkg::OP_LOAD_CLAIM, 1, 1, 3);
    load_entry(bsc_pkg::OP_LOAD_AVAIL, 15, 0, 0);
    load_entry(bsc_pkg::OP_LOAD_AVAIL, 0, 1, 65535);
    launch_check();
    // Starve res 1 below P1's need: nobody fits, verdict unsafe only.
    load_entry(bsc_pkg::OP_LOAD_AVAIL, 7, 1, 2);
    launch_check();
    launch_check();

    // Zero processes: bare safe verdict.
    settle_block();
    write_reg(bsc_pkg::CFG_PROCS_IN_USE, 5'd0);
    launch_check();

    // Zero resources: everyone qualifies, order 0,1.
    settle_block();
    write_reg(bsc_pkg::CFG_PROCS_IN_USE, 5'd2);
    write_reg(bsc_pkg::CFG_RES_IN_USE, 5'd0);
    launch_check();

    // Undecoded register indexes must leave the settings untouched.
    settle_block();
    write_reg(CFG_IDX_SPARE_HI, 5'd31);
    write_reg(CFG_IDX_SPARE_LO, 5'd0);
    launch_check();

    // Random part: three idle profiles, three register settings each.
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 74 : 0;
      for (int s = 0; s < 3; s++) begin
        settle_block();
        write_reg(bsc_pkg::CFG_PROCS_IN_USE, plan_procs[ph * 3 + s][4:0]);
        write_reg(bsc_pkg::CFG_RES_IN_USE, plan_res[ph * 3 + s][4:0]);
        repeat (2) begin
          repeat ($urandom_range(0, 1)) random_load();
          fill_tables();
          launch_check();
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== bankers_safety_check.f =====
rtl/core/bsc_pkg.sv
rtl/core/bsc_ram.sv
rtl/core/bankers_safety_check.sv
rtl/core/bsc_checker.sv
sim/tb_bankers_safety_check.sv
